@@ design/fragment_gap_tracker_core_macros.svh @@
// Assertion macros for the fragment gap tracker core.
// Included by fragment_gap_tracker_core; the macros expand to nothing when SYNTH is set.
`ifndef FRAGMENT_GAP_TRACKER_CORE_MACROS_SVH
`define FRAGMENT_GAP_TRACKER_CORE_MACROS_SVH

`ifndef SYNTH

`define FGT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fgt check failed");

`define FGT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fgt check failed");

`else

`define FGT_ASSERT_IMP(lbl, ante, cons)

`define FGT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ design/fgt_pkg.sv @@
// Types and constants of the fragment gap tracker core.
// Used by fragment_gap_tracker_core; depends on nothing.
`default_nettype none

package fgt_pkg;

  localparam int MAX_FRAGMENTS = 128;
  localparam int IDX_W         = 7;
  localparam int TOT_W         = 8;
  localparam int SEQ_W         = 32;
  localparam int ROW_LSB       = 3;
  localparam int ROW_BITS      = 1 << ROW_LSB;
  localparam int NUM_ROWS      = (MAX_FRAGMENTS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW        = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  localparam logic [TOT_W-1:0] TIMEOUT_RESET = 8'd3;

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KIND_NEW  = 3'd0,
    KIND_DUP  = 3'd1,
    KIND_DONE = 3'd2,
    KIND_RETX = 3'd3,
    KIND_OOR  = 3'd4
  } kind_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] fragment_index;
    logic [TOT_W-1:0] fragment_total;
  } req_t;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] run_start;
    logic [TOT_W-1:0] run_length;
    logic [SEQ_W-1:0] request_seq;
    logic [TOT_W-1:0] received_count;
    logic             last_of_run;
  } rsp_t;

endpackage

`default_nettype wire

@@ design/fgt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; holds the bitmap rows of the fragment gap tracker core.
`default_nettype none

module fgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // The read data holds until the next read is issued.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/fragment_gap_tracker_core.sv @@
// Fragment arrival: accepted with start, busy for one cycle (ST_ARR), then result strobed.
// Tick that does not expire: done at acceptance, no result; busy stays low.
// Expiring tick: bit-serial walk over the bitmap RAM, one bit per cycle, then a final step
// ends it; one row read per 8 bits; a run is strobed when the next opens or at the end.
// Reset (rst_ni low, async) clears control state; per-row valid flags stand in for
// clearing the bitmap RAM, so no clearing pass. Results cannot be held off by the receiver.
`default_nettype none

`include "fragment_gap_tracker_core_macros.svh"

module fragment_gap_tracker_core
  import fgt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             req_i,
  output logic                  result_valid_o,
  output rsp_t                  rsp_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [TOT_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ARR  = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  function automatic logic [ROW_AW-1:0] row_of(input logic [TOT_W-1:0] v);
    row_of = v[ROW_LSB +: ROW_AW];
  endfunction

  state_e               state_q, state_d;
  logic                 active_q, active_d;
  logic [TOT_W-1:0]     total_q, total_d;
  logic [TOT_W-1:0]     got_q, got_d;
  logic [TOT_W-1:0]     countdown_q, countdown_d;
  logic [SEQ_W-1:0]     seq_q, seq_d;
  logic [TOT_W-1:0]     timeout_q;
  logic [NUM_ROWS-1:0]  row_valid_q, row_valid_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [TOT_W-1:0]     scan_q, scan_d;
  logic                 in_run_q, in_run_d;
  logic [IDX_W-1:0]     run_start_q, run_start_d;
  logic                 pend_v_q, pend_v_d;
  logic [IDX_W-1:0]     pend_start_q, pend_start_d;
  logic [TOT_W-1:0]     pend_len_q, pend_len_d;
  rsp_t                 rsp_q, rsp_d;
  logic                 rsp_valid_q, rsp_valid_d;

  logic                 accept;
  logic [TOT_W-1:0]     total_clamped;
  logic                 ram_we, ram_re;
  logic [ROW_AW-1:0]    ram_waddr, ram_raddr;
  logic [ROW_BITS-1:0]  ram_wdata, ram_rdata;
  logic [ROW_AW-1:0]    arr_row;
  logic [ROW_BITS-1:0]  arr_data;
  logic                 arr_oob;
  logic [TOT_W-1:0]     got_inc;
  logic [TOT_W-1:0]     scan_next;
  logic                 scan_bit;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_comb begin
    total_clamped = req_i.fragment_total;
    if (req_i.fragment_total == '0) begin
      total_clamped = TOT_W'(1);
    end else if (req_i.fragment_total > TOT_W'(MAX_FRAGMENTS)) begin
      total_clamped = TOT_W'(MAX_FRAGMENTS);
    end
  end

  // Arrival datapath; rows not written in this session read as all zero.
  assign arr_row   = row_of({1'b0, idx_q});
  assign arr_data  = row_valid_q[arr_row] ? ram_rdata : '0;
  assign arr_oob   = ({1'b0, idx_q} >= total_q);
  assign got_inc   = got_q + TOT_W'(1);
  assign scan_next = scan_q + TOT_W'(1);
  assign scan_bit  = row_valid_q[row_of(scan_q)] && ram_rdata[scan_q[ROW_LSB-1:0]];

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    total_d      = total_q;
    got_d        = got_q;
    countdown_d  = countdown_q;
    seq_d        = seq_q;
    row_valid_d  = row_valid_q;
    idx_d        = idx_q;
    scan_d       = scan_q;
    in_run_d     = in_run_q;
    run_start_d  = run_start_q;
    pend_v_d     = pend_v_q;
    pend_start_d = pend_start_q;
    pend_len_d   = pend_len_q;
    rsp_d        = rsp_q;
    rsp_valid_d  = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = arr_row;
    ram_wdata    = arr_data | (ROW_BITS'(1) << idx_q[ROW_LSB-1:0]);
    ram_re       = 1'b0;
    ram_raddr    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.op)
            OP_ARRIVAL: begin
              ram_re    = 1'b1;
              ram_raddr = row_of({1'b0, req_i.fragment_index});
              idx_d     = req_i.fragment_index;
              state_d   = ST_ARR;
              if (!active_q) begin
                active_d    = 1'b1;
                total_d     = total_clamped;
                got_d       = '0;
                countdown_d = timeout_q;
                row_valid_d = '0;
              end
            end
            OP_TICK: begin
              if (active_q) begin
                if (countdown_q > TOT_W'(1)) begin
                  countdown_d = countdown_q - TOT_W'(1);
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  scan_d    = '0;
                  in_run_d  = 1'b0;
                  pend_v_d  = 1'b0;
                  state_d   = ST_SCAN;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_ARR: begin
        state_d                    = ST_IDLE;
        rsp_valid_d                = 1'b1;
        rsp_d.run_start            = '0;
        rsp_d.run_length           = '0;
        rsp_d.request_seq          = '0;
        rsp_d.last_of_run          = 1'b1;
        rsp_d.received_count       = got_q;
        priority if (arr_oob) begin
          rsp_d.kind = KIND_OOR;
        end else if (arr_data[idx_q[ROW_LSB-1:0]]) begin
          rsp_d.kind = KIND_DUP;
        end else begin
          ram_we               = 1'b1;
          row_valid_d[arr_row] = 1'b1;
          got_d                = got_inc;
          countdown_d          = timeout_q;
          rsp_d.received_count = got_inc;
          if (got_inc >= total_q) begin
            active_d   = 1'b0;
            rsp_d.kind = KIND_DONE;
          end else begin
            rsp_d.kind = KIND_NEW;
          end
        end
      end

      ST_SCAN: begin
        rsp_d.kind           = KIND_RETX;
        rsp_d.request_seq    = seq_q;
        rsp_d.received_count = got_q;
        if (scan_q >= total_q) begin
          // End of the bitmap: the open or pending run is the last request.
          countdown_d       = timeout_q;
          state_d           = ST_IDLE;
          rsp_d.last_of_run = 1'b1;
          if (in_run_q) begin
            rsp_valid_d      = 1'b1;
            rsp_d.run_start  = run_start_q;
            rsp_d.run_length = scan_q - {1'b0, run_start_q};
            seq_d            = seq_q + SEQ_W'(1);
          end else if (pend_v_q) begin
            rsp_valid_d      = 1'b1;
            rsp_d.run_start  = pend_start_q;
            rsp_d.run_length = pend_len_q;
            seq_d            = seq_q + SEQ_W'(1);
          end
        end else begin
          scan_d = scan_next;
          // Fetch the next row while the last bit of this one is examined.
          if (scan_q[ROW_LSB-1:0] == '1) begin
            ram_re    = 1'b1;
            ram_raddr = row_of(scan_next);
          end
          if (!scan_bit && !in_run_q) begin
            in_run_d    = 1'b1;
            run_start_d = scan_q[IDX_W-1:0];
            // A new run proves the pending one was not the last.
            if (pend_v_q) begin
              pend_v_d          = 1'b0;
              rsp_valid_d       = 1'b1;
              rsp_d.run_start   = pend_start_q;
              rsp_d.run_length  = pend_len_q;
              rsp_d.last_of_run = 1'b0;
              seq_d             = seq_q + SEQ_W'(1);
            end
          end else if (scan_bit && in_run_q) begin
            in_run_d     = 1'b0;
            pend_v_d     = 1'b1;
            pend_start_d = run_start_q;
            pend_len_d   = scan_q - {1'b0, run_start_q};
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  fgt_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (NUM_ROWS)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      total_q     <= '0;
      got_q       <= '0;
      countdown_q <= '0;
      seq_q       <= '0;
      timeout_q   <= TIMEOUT_RESET;
      row_valid_q <= '0;
      scan_q      <= '0;
      in_run_q    <= 1'b0;
      pend_v_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      total_q     <= total_d;
      got_q       <= got_d;
      countdown_q <= countdown_d;
      seq_q       <= seq_d;
      row_valid_q <= row_valid_d;
      scan_q      <= scan_d;
      in_run_q    <= in_run_d;
      pend_v_q    <= pend_v_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    run_start_q  <= run_start_d;
    pend_start_q <= pend_start_d;
    pend_len_q   <= pend_len_d;
    rsp_q        <= rsp_d;
  end

  assign result_valid_o = rsp_valid_q;
  assign rsp_o          = rsp_q;

  `FGT_ASSERT_NXT(a_arrival_enters_rmw, accept && (req_i.op == OP_ARRIVAL), state_q == ST_ARR)
  `FGT_ASSERT_NXT(a_arrival_gives_result, state_q == ST_ARR, result_valid_o)
  `FGT_ASSERT_IMP(a_open_session_incomplete, active_q, got_q < total_q)
  `FGT_ASSERT_IMP(a_request_nonempty, result_valid_o && (rsp_o.kind == KIND_RETX), rsp_o.run_length != '0)

endmodule

`default_nettype wire
